FILE: rtl/assert_macros.svh
// Assertion macros shared by the replacement unit RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, off while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/lpr_pkg.sv
// Package for the LRU page replacement unit: constants and request/result types.
// No dependencies; imported by lpr_cmp_unit, the top module and the testbench.
package lpr_pkg;

  localparam int LPR_MAX_FRAMES = 8;
  localparam int LPR_PAGE_BITS  = 16;
  localparam int LPR_TIME_W     = 32;
  localparam int LPR_CNT_W      = 32;
  localparam int LPR_CFG_W      = 4;
  localparam int LPR_OUT_IDX_W  = 3;

  localparam logic [LPR_CFG_W-1:0]  LPR_CFG_RESET = 4'd8;
  localparam logic [LPR_TIME_W-1:0] LPR_TIME_MAX  = '1;
  localparam logic [LPR_CNT_W-1:0]  LPR_CNT_MAX   = '1;

  typedef struct packed {
    logic [LPR_PAGE_BITS-1:0] page_number;
    logic                     final_request;
  } lpr_in_t;

  typedef struct packed {
    logic                     hit;
    logic [LPR_OUT_IDX_W-1:0] frame_index;
    logic                     evicted_valid;
    logic [LPR_PAGE_BITS-1:0] evicted_page;
    logic [LPR_CNT_W-1:0]     fault_count;
    logic                     run_done;
  } lpr_out_t;

  // One frame as held in the frame memory
  typedef struct packed {
    logic [LPR_PAGE_BITS-1:0] page;
    logic [LPR_TIME_W-1:0]    last_use;
  } lpr_entry_t;

  // Outcome of one walk over the frames
  typedef struct packed {
    logic                     hit;
    logic                     have_empty;
    logic [LPR_PAGE_BITS-1:0] victim_page;
  } lpr_search_t;

endpackage

FILE: rtl/lpr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used for the frame store of the replacement unit.
module lpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

FILE: rtl/lpr_cmp_unit.sv
// Shared compare unit: takes one frame per cycle and keeps the running
// hit, first-empty and oldest-frame results. Depends on lpr_pkg.
`include "assert_macros.svh"
module lpr_cmp_unit
  import lpr_pkg::*;
#(
  parameter int MAX_FRAMES = LPR_MAX_FRAMES,
  localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     clear,
  input  logic                     en,
  input  logic [IW-1:0]            idx,
  input  lpr_entry_t               entry,
  input  logic                     entry_valid,
  input  logic [LPR_PAGE_BITS-1:0] page,
  output lpr_search_t              search,
  output logic [IW-1:0]            hit_idx,
  output logic [IW-1:0]            empty_idx,
  output logic [IW-1:0]            victim_idx
);

  logic                     hit_r;
  logic                     empty_r;
  logic                     seen_r;
  logic [IW-1:0]            hit_idx_r;
  logic [IW-1:0]            empty_idx_r;
  logic [IW-1:0]            min_idx_r;
  logic [LPR_TIME_W-1:0]    min_r;
  logic [LPR_PAGE_BITS-1:0] min_page_r;
  logic                     match;
  logic                     older;

  // The one equality and one magnitude compare shared by the whole walk
  assign match = entry_valid && (entry.page == page);
  assign older = entry_valid && (!seen_r || (entry.last_use < min_r));

  // Keep first hit, first empty frame and strictly oldest frame
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      hit_r   <= 1'b0;
      empty_r <= 1'b0;
      seen_r  <= 1'b0;
    end else if (en) begin
      if (match && !hit_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= idx;
      end
      if (!entry_valid && !empty_r) begin
        empty_r     <= 1'b1;
        empty_idx_r <= idx;
      end
      if (older) begin
        seen_r     <= 1'b1;
        min_r      <= entry.last_use;
        min_idx_r  <= idx;
        min_page_r <= entry.page;
      end
    end
  end

  assign search.hit         = hit_r;
  assign search.have_empty  = empty_r;
  assign search.victim_page = min_page_r;
  assign hit_idx            = hit_idx_r;
  assign empty_idx          = empty_idx_r;
  assign victim_idx         = min_idx_r;

  // A frame that takes part in the walk is either empty or timed
  `ASSERT_CLK(a_cmp_seen_or_empty, (en && !clear) |=> (seen_r || empty_r),
              "compare unit saw a frame but recorded nothing")

endmodule

FILE: rtl/lru_page_replacement_unit.sv
// LRU page replacement unit: timestamp LRU over up to MAX_FRAMES frames.
// Each request walks the active frames in ST_SCAN, drains the read pipe in ST_DRAIN
// and writes back in ST_WRITE; one frame is read per cycle from the frame RAM.
// A new request is taken only when idle; busy drops as the result shows.
// Reset (synchronous, rst_n low): all frames empty, clock and fault count zero,
// frame count 8. The receiver cannot stall; each result stands for one cycle.
`include "assert_macros.svh"
module lru_page_replacement_unit
  import lpr_pkg::*;
#(
  parameter int MAX_FRAMES = LPR_MAX_FRAMES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  lpr_in_t              in_data,
  output logic                 out_valid,
  output lpr_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [LPR_CFG_W-1:0] cfg_wdata
);

  localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW = IW + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_WRITE
  } state_t;

  state_t                  state_r;
  logic [LPR_CFG_W-1:0]    cfg_r;
  lpr_in_t                 req_r;
  logic [IW-1:0]           idx_r;
  logic                    cmp_vld_r;
  logic [IW-1:0]           cmp_idx_r;
  logic [MAX_FRAMES-1:0]   valid_r;
  logic [LPR_TIME_W-1:0]   clock_r;
  logic [LPR_CNT_W-1:0]    faults_r;
  logic                    out_valid_r;
  lpr_out_t                out_r;

  logic [CW-1:0]           n_act;
  logic [IW-1:0]           last_idx;
  logic                    accept;
  lpr_entry_t              rd_entry;
  lpr_entry_t              wr_entry;
  lpr_search_t             search;
  logic [IW-1:0]           hit_idx;
  logic [IW-1:0]           empty_idx;
  logic [IW-1:0]           victim_idx;
  logic [IW-1:0]           slot;
  logic                    evict;
  logic [LPR_CNT_W-1:0]    faults_nxt;
  logic [LPR_TIME_W-1:0]   clock_nxt;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // Clamp the frame count to one..MAX_FRAMES
  always_comb begin
    if (cfg_r == '0) begin
      n_act = CW'(1);
    end else if (32'(cfg_r) > MAX_FRAMES) begin
      n_act = CW'(MAX_FRAMES);
    end else begin
      n_act = CW'(cfg_r);
    end
  end
  assign last_idx = IW'(n_act - CW'(1));

  // Pick the frame and work out the counters for the write-back cycle
  always_comb begin
    if (search.hit) begin
      slot = hit_idx;
    end else if (search.have_empty) begin
      slot = empty_idx;
    end else begin
      slot = victim_idx;
    end
    evict = !search.hit && !search.have_empty;
    if (!search.hit && (faults_r != LPR_CNT_MAX)) begin
      faults_nxt = faults_r + LPR_CNT_W'(1);
    end else begin
      faults_nxt = faults_r;
    end
    if (clock_r != LPR_TIME_MAX) begin
      clock_nxt = clock_r + LPR_TIME_W'(1);
    end else begin
      clock_nxt = clock_r;
    end
  end

  assign wr_entry.page     = req_r.page_number;
  assign wr_entry.last_use = clock_r;

  lpr_ram #(
    .WIDTH ($bits(lpr_entry_t)),
    .DEPTH (MAX_FRAMES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (state_r == ST_WRITE),
    .waddr (slot),
    .wdata (wr_entry),
    .raddr (idx_r),
    .rdata (rd_entry)
  );

  lpr_cmp_unit #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_cmp (
    .clk         (clk),
    .rst_n       (rst_n),
    .clear       (accept),
    .en          (cmp_vld_r),
    .idx         (cmp_idx_r),
    .entry       (rd_entry),
    .entry_valid (valid_r[cmp_idx_r]),
    .page        (req_r.page_number),
    .search      (search),
    .hit_idx     (hit_idx),
    .empty_idx   (empty_idx),
    .victim_idx  (victim_idx)
  );

  // Sequencer: walk the frames, drain the read pipe, write back and report
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_r       <= LPR_CFG_RESET;
      cmp_vld_r   <= 1'b0;
      valid_r     <= '0;
      clock_r     <= '0;
      faults_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      cmp_vld_r   <= (state_r == ST_SCAN);
      cmp_idx_r   <= idx_r;
      out_valid_r <= (state_r == ST_WRITE);
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            req_r   <= in_data;
            idx_r   <= '0;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (idx_r == last_idx) begin
            state_r <= ST_DRAIN;
          end else begin
            idx_r <= idx_r + IW'(1);
          end
        end
        ST_DRAIN: begin
          state_r <= ST_WRITE;
        end
        ST_WRITE: begin
          out_r.hit             <= search.hit;
          out_r.frame_index     <= LPR_OUT_IDX_W'(slot);
          out_r.evicted_valid   <= evict;
          out_r.evicted_page    <= evict ? search.victim_page : '0;
          out_r.fault_count     <= faults_nxt;
          out_r.run_done        <= req_r.final_request;
          // End of run: empty every frame and restart the counters
          if (req_r.final_request) begin
            valid_r  <= '0;
            clock_r  <= '0;
            faults_r <= '0;
          end else begin
            valid_r[slot] <= 1'b1;
            clock_r       <= clock_nxt;
            faults_r      <= faults_nxt;
          end
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ASSERT_CLK(a_res_after_write, out_valid |-> $past(state_r == ST_WRITE),
              "result strobe without a write-back cycle")
  `ASSERT_CLK(a_accept_goes_busy, (start && !busy) |=> busy,
              "accepted request did not make the unit busy")
  `ASSERT_CLK(a_hit_no_evict, (out_valid && out_data.hit) |-> !out_data.evicted_valid,
              "hit reported together with an eviction")
  `ASSERT_CLK(a_miss_counts, (out_valid && !out_data.hit) |-> (out_data.fault_count != '0),
              "fault reported with a zero fault count")

endmodule

FILE: bench/tb_lru_page_replacement_unit.sv
// Testbench for lru_page_replacement_unit: directed and random page requests checked
// against a timestamp LRU predictor held in a small scoreboard class.
// Depends on lpr_pkg (request/result structs, widths, reset frame count) and the RTL top.
module tb_lru_page_replacement_unit;
  import lpr_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASE_ITEMS  = 600;
  localparam int MAX_REPORTS  = 10;
  localparam int RUN_LIMIT    = 4000000; // time units

  // Predicts one result per request and checks the results against it
  class lru_scoreboard;
    logic [LPR_CFG_W-1:0]                         frames_cfg;
    logic [LPR_MAX_FRAMES-1:0][LPR_PAGE_BITS-1:0] page_of;
    logic [LPR_MAX_FRAMES-1:0]                    occupied;
    logic [LPR_MAX_FRAMES-1:0][LPR_TIME_W-1:0]    used_at;
    logic [LPR_TIME_W-1:0]                        req_clock;
    logic [LPR_CNT_W-1:0]                         faults;
    lpr_out_t                                     expected_q[$];
    int                                           mismatches;

    function new();
      frames_cfg = LPR_CFG_RESET;
      mismatches = 0;
      clear_run();
    endfunction

    // Empty every frame and restart the run counters
    function void clear_run();
      page_of   = '0;
      occupied  = '0;
      used_at   = '0;
      req_clock = '0;
      faults    = '0;
    endfunction

    function void set_frames(logic [LPR_CFG_W-1:0] value);
      frames_cfg = value;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    // Work out the result of one accepted request and queue it
    function void note_request(lpr_in_t req);
      int       n;
      int       slot;
      bit       found;
      bit       have_empty;
      lpr_out_t res;
      logic [LPR_TIME_W-1:0] oldest;
      n = (frames_cfg == 0) ? 1 :
          (frames_cfg > LPR_MAX_FRAMES) ? LPR_MAX_FRAMES : int'(frames_cfg);
      slot = 0;
      found = 0;
      have_empty = 0;
      res = '0;
      // look up the page among the frames in use, lowest index first
      for (int i = 0; i < n; i++) begin
        if (!found && occupied[i] && page_of[i] == req.page_number) begin
          found = 1;
          slot = i;
        end
      end
      if (!found) begin
        if (faults != LPR_CNT_MAX) faults = faults + LPR_CNT_W'(1);
        for (int i = 0; i < n; i++) begin
          if (!have_empty && !occupied[i]) begin
            have_empty = 1;
            slot = i;
          end
        end
        // no empty frame: evict the oldest, ties to the lower index
        if (!have_empty) begin
          oldest = used_at[0];
          slot = 0;
          for (int i = 1; i < n; i++) begin
            if (used_at[i] < oldest) begin
              oldest = used_at[i];
              slot = i;
            end
          end
          res.evicted_valid = 1'b1;
          res.evicted_page  = page_of[slot];
        end
        page_of[slot]  = req.page_number;
        occupied[slot] = 1'b1;
      end
      used_at[slot] = req_clock;
      if (req_clock != LPR_TIME_MAX) req_clock = req_clock + LPR_TIME_W'(1);
      res.hit         = found;
      res.frame_index = slot[LPR_OUT_IDX_W-1:0];
      res.fault_count = faults;
      res.run_done    = req.final_request;
      expected_q.push_back(res);
      if (req.final_request) clear_run();
    endfunction

    // Compare one result with the oldest expectation, field by field
    function void check_result(lpr_out_t got);
      lpr_out_t exp_res;
      bit       bad;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with no request outstanding: hit=%0b frame=%0d",
                   $realtime, got.hit, got.frame_index);
        return;
      end
      exp_res = expected_q.pop_front();
      bad = (got.hit !== exp_res.hit) || (got.frame_index !== exp_res.frame_index) ||
            (got.evicted_valid !== exp_res.evicted_valid) ||
            (got.evicted_page !== exp_res.evicted_page) ||
            (got.fault_count !== exp_res.fault_count) ||
            (got.run_done !== exp_res.run_done);
      if (bad) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: expected hit=%0b frame=%0d ev=%0b ev_page=%h faults=%0d done=%0b",
                   $realtime, exp_res.hit, exp_res.frame_index, exp_res.evicted_valid,
                   exp_res.evicted_page, exp_res.fault_count, exp_res.run_done);
          $display("%0t: actual   hit=%0b frame=%0d ev=%0b ev_page=%h faults=%0d done=%0b",
                   $realtime, got.hit, got.frame_index, got.evicted_valid,
                   got.evicted_page, got.fault_count, got.run_done);
        end
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  lpr_in_t              in_data = '0;
  logic                 out_valid;
  lpr_out_t             out_data;
  logic                 cfg_we = 1'b0;
  logic [LPR_CFG_W-1:0] cfg_wdata = '0;

  lru_scoreboard        book;
  logic [LPR_PAGE_BITS-1:0] run_base;
  logic [LPR_CFG_W-1:0] frames_now;

  lru_page_replacement_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  // Watch the ports at the rising edge: results, accepted requests, register writes
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) book.check_result(out_data);
      if (start && !busy) book.note_request(in_data);
      if (cfg_we) book.set_frames(cfg_wdata);
    end
  end

  // Offer one request, hold it until accepted, then idle at random
  task automatic send_request(logic [LPR_PAGE_BITS-1:0] page, bit last, int idle_pct);
    lpr_in_t req;
    req.page_number   = page;
    req.final_request = last;
    start   <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
    @(negedge clk);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  // Hold the sender off until every outstanding request has its result
  task automatic wait_drain();
    start <= 1'b0;
    while (book.outstanding() != 0) @(negedge clk);
  endtask

  // Write the frame count once the block has gone quiet
  task automatic write_frames(logic [LPR_CFG_W-1:0] value);
    wait_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we     <= 1'b1;
    cfg_wdata  <= value;
    frames_now = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly pages from a small pool around the run's base, so hits and evictions occur
  function automatic logic [LPR_PAGE_BITS-1:0] pick_page();
    int pick;
    int span;
    pick = $urandom_range(0, 99);
    span = (frames_now == 0) ? 3 : (frames_now > 8) ? 10 : int'(frames_now) + 2;
    if (pick < 75) return run_base + LPR_PAGE_BITS'($urandom_range(0, span));
    if (pick < 82) return '0;
    if (pick < 89) return '1;
    return LPR_PAGE_BITS'($urandom);
  endfunction

  initial begin
    int idle_pct;
    int next_cfg;
    int next_pause;
    int pick;
    bit last;
    book = new();
    run_base = '0;
    frames_now = LPR_CFG_RESET;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: fill, hit, evict with four frames
    write_frames(4'd4);
    send_request(16'h0000, 1'b0, 26);
    send_request(16'hFFFF, 1'b0, 26);
    send_request(16'h0001, 1'b0, 26);
    send_request(16'h0002, 1'b0, 26);
    send_request(16'h0000, 1'b0, 26);
    send_request(16'h0003, 1'b0, 26);
    send_request(16'h0001, 1'b0, 26);
    send_request(16'h0004, 1'b0, 26);
    send_request(16'h8000, 1'b1, 26);
    // zero frames acts as one
    write_frames(4'd0);
    send_request(16'h1234, 1'b0, 0);
    send_request(16'h1234, 1'b0, 0);
    send_request(16'h4321, 1'b0, 0);
    // above the maximum acts as eight, changed mid-run
    write_frames(4'd15);
    send_request(16'h1234, 1'b0, 0);
    send_request(16'h4321, 1'b0, 0);
    send_request(16'hABCD, 1'b1, 0);
    // shrink mid-run: frames beyond the count are kept but not searched
    write_frames(4'd8);
    send_request(16'h0010, 1'b0, 26);
    send_request(16'h0011, 1'b0, 26);
    send_request(16'h0012, 1'b0, 26);
    send_request(16'h0013, 1'b0, 26);
    write_frames(4'd2);
    send_request(16'h0013, 1'b0, 26);
    write_frames(4'd8);
    send_request(16'h0013, 1'b0, 26);
    send_request(16'h0012, 1'b1, 26);
    wait_drain();

    // Random: sender idles seldom, then often, then never
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 26 : (phase == 1) ? 69 : 0;
      next_cfg = $urandom_range(60, 150);
      next_pause = $urandom_range(100, 250);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == next_cfg) begin
          pick = $urandom_range(0, 9);
          case (pick)
            0:       write_frames(4'd0);
            1:       write_frames(4'd15);
            2:       write_frames(4'd1);
            3:       write_frames(4'd8);
            default: write_frames(LPR_CFG_W'($urandom_range(0, 15)));
          endcase
          next_cfg = k + $urandom_range(60, 150);
        end else if (k == next_pause) begin
          wait_drain();
          next_pause = k + $urandom_range(100, 250);
        end
        last = ($urandom_range(0, 29) == 0);
        send_request(pick_page(), last, idle_pct);
        if (last) run_base = LPR_PAGE_BITS'($urandom);
      end
    end

    // Drain and let the block settle before the verdict
    wait_drain();
    repeat (DRAIN_CYCLES * 2) @(posedge clk);
    if (book.mismatches == 0 && book.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #RUN_LIMIT;
    $display("FAILURE");
    $finish;
  end

endmodule
